[design/shp3_pkg.sv]
// Shared types and constants for the 3x3 sharpen core.
`timescale 1ns / 1ps
`default_nettype none

package shp3_pkg;

    localparam int DIM_W       = 10;
    localparam int COORD_W     = 9;
    localparam int CHAN_W      = 8;
    localparam int PIX_W       = 3 * CHAN_W;
    localparam int ACC_W       = 13;
    localparam int TAP_W       = 4;
    localparam int CFG_INDEX_W = 2;

    localparam logic [DIM_W-1:0] DIM_MIN   = 10'd3;
    localparam logic [DIM_W-1:0] DIM_RESET = 10'd512;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [TAP_W-1:0] TAP_FIRST  = 4'd0;
    localparam logic [TAP_W-1:0] TAP_CENTER = 4'd4;
    localparam logic [TAP_W-1:0] TAP_LAST   = 4'd8;

    typedef struct packed {
        logic             load;
        logic             wr_en;
        logic             rd_en;
        logic [TAP_W-1:0] tap;
        logic             out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic in_range;
        logic is_query;
        logic out_free;
    } ctl_sts_t;

endpackage

`default_nettype wire

[design/shp3_ctrl.sv]
// Controller state machine: sequences store, tap reads and result load.
`timescale 1ns / 1ps
`default_nettype none

module shp3_ctrl
    import shp3_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire ctl_sts_t sts,
    output ctl_cmd_t      cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECIDE = 5'b00010,
        ST_READ   = 5'b00100,
        ST_FLUSH  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [TAP_W-1:0] tap_reg, tap_next;

    always_comb begin
        state_next   = state_reg;
        tap_next     = tap_reg;
        cmd.load     = 1'b0;
        cmd.wr_en    = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.tap      = tap_reg;
        cmd.out_load = 1'b0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                tap_next = TAP_FIRST;
                cmd.tap  = TAP_CENTER;
                if (sts.in_range && sts.is_query) begin
                    state_next = ST_READ;
                end else begin
                    cmd.wr_en  = sts.in_range;
                    state_next = ST_FINISH;
                end
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
                tap_next  = tap_reg + 1'b1;
                if (tap_reg == TAP_LAST) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tap_reg   <= TAP_FIRST;
        end else begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

`ifndef SYNTH
    a_tap_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (tap_reg <= TAP_LAST))
        else $error("tap counter past last tap");
    a_flush_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> ($past(tap_reg) == TAP_LAST))
        else $error("flush entered before last tap");
`endif

endmodule

`default_nettype wire

[design/shp3_datapath.sv]
// Datapath: config registers, frame memory, tap addressing, accumulators, output.
`timescale 1ns / 1ps
`default_nettype none

module shp3_datapath
    import shp3_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]       cfg_data,
    input  wire logic                   s_operation,
    input  wire logic [COORD_W-1:0]     s_row,
    input  wire logic [COORD_W-1:0]     s_col,
    input  wire logic [CHAN_W-1:0]      s_in_red,
    input  wire logic [CHAN_W-1:0]      s_in_green,
    input  wire logic [CHAN_W-1:0]      s_in_blue,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [CHAN_W-1:0]           m_out_red,
    output logic [CHAN_W-1:0]           m_out_green,
    output logic [CHAN_W-1:0]           m_out_blue,
    output logic                        m_clipped,
    input  wire ctl_cmd_t               cmd,
    output ctl_sts_t                    sts
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [DIM_W-1:0] eff_w, eff_h;

    logic             in_range_reg, is_query_reg;
    logic [DIM_W-1:0] row_m_reg, row_c_reg, row_p_reg;
    logic [DIM_W-1:0] col_m_reg, col_c_reg, col_p_reg;
    logic [PIX_W-1:0] pix_reg;

    logic [DIM_W-1:0] row_sel, col_sel;
    logic [AW-1:0]    addr;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;
    logic             acc_en_reg, center_reg;
    logic signed [ACC_W-1:0] acc_reg [3];

    logic             m_valid_reg;
    logic [CHAN_W-1:0] res_reg [3];
    logic             clip_reg;

    logic [CHAN_W-1:0] sat [3];
    logic [2:0]        sat_hit;

    logic [DIM_W-1:0] row_ext, col_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_IMAGE_WIDTH) begin
                width_reg <= cfg_data;
            end else if (cfg_index == REG_IMAGE_HEIGHT) begin
                height_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        if (width_reg < DIM_MIN) begin
            eff_w = DIM_MIN;
        end else if (int'(width_reg) > MAX_WIDTH) begin
            eff_w = DIM_W'(MAX_WIDTH);
        end else begin
            eff_w = width_reg;
        end
        if (height_reg < DIM_MIN) begin
            eff_h = DIM_MIN;
        end else if (int'(height_reg) > MAX_HEIGHT) begin
            eff_h = DIM_W'(MAX_HEIGHT);
        end else begin
            eff_h = height_reg;
        end
    end

    assign row_ext = DIM_W'(s_row);
    assign col_ext = DIM_W'(s_col);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_range_reg <= (row_ext < eff_h) && (col_ext < eff_w);
            is_query_reg <= (s_operation == OP_QUERY);
            row_c_reg    <= row_ext;
            col_c_reg    <= col_ext;
            row_m_reg    <= (s_row == '0) ? eff_h - 1'b1 : row_ext - 1'b1;
            col_m_reg    <= (s_col == '0) ? eff_w - 1'b1 : col_ext - 1'b1;
            row_p_reg    <= (row_ext + 1'b1 >= eff_h) ? '0 : row_ext + 1'b1;
            col_p_reg    <= (col_ext + 1'b1 >= eff_w) ? '0 : col_ext + 1'b1;
            pix_reg      <= {s_in_red, s_in_green, s_in_blue};
        end
    end

    always_comb begin
        unique case (cmd.tap) inside
            4'd0, 4'd1, 4'd2: row_sel = row_m_reg;
            4'd3, 4'd4, 4'd5: row_sel = row_c_reg;
            default:          row_sel = row_p_reg;
        endcase
        unique case (cmd.tap) inside
            4'd0, 4'd3, 4'd6: col_sel = col_m_reg;
            4'd1, 4'd4, 4'd7: col_sel = col_c_reg;
            default:          col_sel = col_p_reg;
        endcase
    end

    assign addr = AW'(int'(row_sel) * MAX_WIDTH + int'(col_sel));

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[addr] <= pix_reg;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_en_reg <= 1'b0;
        end else begin
            acc_en_reg <= cmd.rd_en;
        end
        center_reg <= (cmd.tap == TAP_CENTER);
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 3; c++) begin
            if (cmd.load) begin
                acc_reg[c] <= '0;
            end else if (acc_en_reg) begin
                if (center_reg) begin
                    acc_reg[c] <= acc_reg[c]
                        + $signed(ACC_W'({rdata_reg[PIX_W-1-CHAN_W*c -: CHAN_W], 3'b000}))
                        + $signed(ACC_W'(rdata_reg[PIX_W-1-CHAN_W*c -: CHAN_W]));
                end else begin
                    acc_reg[c] <= acc_reg[c]
                        - $signed(ACC_W'(rdata_reg[PIX_W-1-CHAN_W*c -: CHAN_W]));
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (acc_reg[c] < 0) begin
                sat[c]     = '0;
                sat_hit[c] = 1'b1;
            end else if (acc_reg[c] > $signed(ACC_W'(255))) begin
                sat[c]     = '1;
                sat_hit[c] = 1'b1;
            end else begin
                sat[c]     = acc_reg[c][CHAN_W-1:0];
                sat_hit[c] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            res_reg[0] <= sat[0];
            res_reg[1] <= sat[1];
            res_reg[2] <= sat[2];
            clip_reg   <= |sat_hit;
        end
    end

    assign sts.in_range = in_range_reg;
    assign sts.is_query = is_query_reg;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_out_red   = res_reg[0];
    assign m_out_green = res_reg[1];
    assign m_out_blue  = res_reg[2];
    assign m_clipped   = clip_reg;

`ifndef SYNTH
    a_port_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wr_en && cmd.rd_en))
        else $error("memory read and write in one cycle");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over an untaken word");
    a_clip_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_clipped) |->
            (m_out_red == 8'd0 || m_out_red == 8'd255 ||
             m_out_green == 8'd0 || m_out_green == 8'd255 ||
             m_out_blue == 8'd0 || m_out_blue == 8'd255))
        else $error("clip flag without a saturated channel");
`endif

endmodule

`default_nettype wire

[design/sharpen_3x3_wraparound_core.sv]
// Top level of the 3x3 sharpen core over a wraparound frame store.
//
// Input channel (s_*): one word per item. s_operation selects a pixel store
// or a sharpen query at (s_row, s_col); store words carry the RGB pixel.
// Result channel (m_*): exactly one word per input word. Queries return the
// saturated 9*center minus eight-neighbor sum per channel, with neighbors
// wrapping at the image edges, plus a clip flag. Stores and out-of-range
// coordinates return all zeros.
// Config channel (cfg_*): index 0 image width, index 1 image height; always
// ready, write only while the core is idle.
// Sequence: a query goes accept, decide, tap reads, flush, result load;
// other words go from decide to the load. Nine taps are read one per cycle
// from the single-port frame memory. s_ready waits for the result load.
// Reset (aresetn low, synchronous) returns the dims to 512x512 and clears the
// handshake state; frame contents stay undefined until written.
// A stalled receiver holds the result word; a finished item then waits
// until the output register frees, and no new word is accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module sharpen_3x3_wraparound_core
    import shp3_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]       cfg_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_operation,
    input  wire logic [COORD_W-1:0]     s_row,
    input  wire logic [COORD_W-1:0]     s_col,
    input  wire logic [CHAN_W-1:0]      s_in_red,
    input  wire logic [CHAN_W-1:0]      s_in_green,
    input  wire logic [CHAN_W-1:0]      s_in_blue,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [CHAN_W-1:0]           m_out_red,
    output logic [CHAN_W-1:0]           m_out_green,
    output logic [CHAN_W-1:0]           m_out_blue,
    output logic                        m_clipped
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    assign cfg_ready = 1'b1;

    shp3_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    shp3_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_operation (s_operation),
        .s_row       (s_row),
        .s_col       (s_col),
        .s_in_red    (s_in_red),
        .s_in_green  (s_in_green),
        .s_in_blue   (s_in_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_clipped   (m_clipped),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire
